// File: hw/rtl/sma_pkg.sv
// shared constants and types for the symmetric moving average core
package sma_pkg;

   // window and sample geometry
   localparam int WINDOW_LENGTH = 17;
   localparam int SAMPLE_BITS   = 16;
   localparam int HALF_WIN      = WINDOW_LENGTH / 2;
   localparam int LAG           = WINDOW_LENGTH - 1 - HALF_WIN;

   // position tracking, saturating at the window length
   localparam int COUNT_BITS = $clog2(WINDOW_LENGTH + 1);
   localparam int POS_BITS   = COUNT_BITS + 2;

   // weighted taps carry up to three copies of a sample
   localparam int TERM_BITS   = SAMPLE_BITS + 2;
   localparam int SUM_BITS    = SAMPLE_BITS + $clog2(WINDOW_LENGTH);
   localparam int GROUP_SIZE  = 4;
   localparam int GROUP_COUNT = (WINDOW_LENGTH + GROUP_SIZE - 1) / GROUP_SIZE;

   // rounded divide: (2*|sum| + L) / (2*L) through a reciprocal
   localparam int DIVISOR     = 2 * WINDOW_LENGTH;
   localparam int NUM_BITS    = SUM_BITS + 1;
   localparam int RECIP_SHIFT = NUM_BITS + 1;
   localparam int RECIP_BITS  = RECIP_SHIFT - $clog2(DIVISOR) + 1;
   localparam longint unsigned RECIP = (64'd1 << RECIP_SHIFT) / DIVISOR;
   localparam int EST_BITS    = RECIP_BITS - 1;
   localparam int PROD_BITS   = NUM_BITS + RECIP_BITS;

   // queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] sample;
      logic                          last_sample;
   } req_type;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] window_mean;
      logic                          last_result;
      logic                          short_record;
   } rsp_type;

   typedef struct packed {
      logic signed [SUM_BITS-1:0] sum;
      logic                       last_result;
      logic                       short_record;
   } entry_type;

endpackage

// File: hw/rtl/sma_front.sv
// front end: sample history, record position tracking, window weighting and adder tree
module sma_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  sma_pkg::req_type      req_data,
   output logic                  push_valid,
   input  logic                  push_ready,
   output sma_pkg::entry_type    push_entry
);

   logic signed [sma_pkg::SAMPLE_BITS-1:0] history_ff [sma_pkg::WINDOW_LENGTH];
   logic [sma_pkg::COUNT_BITS-1:0]         seen_ff, seen_in;

   logic                                   job_valid_ff, job_valid_in;
   logic [sma_pkg::COUNT_BITS-1:0]         job_t_ff, job_t_in;
   logic [sma_pkg::COUNT_BITS-1:0]         job_n_ff, job_n_in;
   logic                                   job_end_ff, job_end_in;
   logic                                   job_short_ff, job_short_in;

   logic                                   term_valid_ff;
   logic signed [sma_pkg::TERM_BITS-1:0]   term_ff [sma_pkg::WINDOW_LENGTH];
   logic signed [sma_pkg::TERM_BITS-1:0]   term_in [sma_pkg::WINDOW_LENGTH];
   logic                                   term_last_ff, term_short_ff;

   logic                                   part_valid_ff;
   logic signed [sma_pkg::SUM_BITS-1:0]    part_ff [sma_pkg::GROUP_COUNT];
   logic signed [sma_pkg::SUM_BITS-1:0]    part_in [sma_pkg::GROUP_COUNT];
   logic                                   part_last_ff, part_short_ff;

   logic                                   req_take, job_take, job_done, job_last;
   logic                                   term_ready, part_ready;
   logic [sma_pkg::COUNT_BITS-1:0]         n_next;
   logic signed [sma_pkg::POS_BITS-1:0]    win_lo, win_hi;
   logic signed [sma_pkg::POS_BITS-1:0]    pos [sma_pkg::WINDOW_LENGTH];
   logic signed [sma_pkg::POS_BITS-1:0]    mirror_left [sma_pkg::WINDOW_LENGTH];
   logic signed [sma_pkg::POS_BITS-1:0]    mirror_right [sma_pkg::WINDOW_LENGTH];
   logic                                   in_record [sma_pkg::WINDOW_LENGTH];
   logic                                   self_hit [sma_pkg::WINDOW_LENGTH];
   logic                                   left_hit [sma_pkg::WINDOW_LENGTH];
   logic                                   right_hit [sma_pkg::WINDOW_LENGTH];
   logic [1:0]                             weight [sma_pkg::WINDOW_LENGTH];
   logic signed [sma_pkg::TERM_BITS-1:0]   wide [sma_pkg::WINDOW_LENGTH];
   logic signed [sma_pkg::SUM_BITS-1:0]    total;

   // stage handshakes
   always_comb begin
      part_ready = !part_valid_ff || push_ready;
      term_ready = !term_valid_ff || part_ready;
      job_done   = !job_end_ff || job_short_ff ||
                   (job_t_ff == job_n_ff - sma_pkg::COUNT_BITS'(1));
      job_last   = job_end_ff && job_done;
      job_take   = job_valid_ff && term_ready;
      req_ready  = !job_valid_ff || (term_ready && job_done);
      req_take   = req_valid && req_ready;
   end

   // sample history, newest at index zero
   always_ff @(posedge clock) begin
      if (req_take) begin
         history_ff[0] <= req_data.sample;
         for (int i = 1; i < sma_pkg::WINDOW_LENGTH; i++) begin
            history_ff[i] <= history_ff[i-1];
         end
      end
   end

   // record position and result job sequencing
   always_comb begin
      if (seen_ff >= sma_pkg::COUNT_BITS'(sma_pkg::WINDOW_LENGTH)) begin
         n_next = sma_pkg::COUNT_BITS'(sma_pkg::WINDOW_LENGTH);
      end else begin
         n_next = seen_ff + sma_pkg::COUNT_BITS'(1);
      end
      seen_in      = seen_ff;
      job_valid_in = job_valid_ff;
      job_t_in     = job_t_ff;
      job_n_in     = job_n_ff;
      job_end_in   = job_end_ff;
      job_short_in = job_short_ff;
      // step through the flush positions of a final sample
      if (job_take) begin
         if (job_done) begin
            job_valid_in = 1'b0;
         end else begin
            job_t_in = job_t_ff + sma_pkg::COUNT_BITS'(1);
         end
      end
      // a new sample opens a new job
      if (req_take) begin
         job_n_in     = n_next;
         job_end_in   = req_data.last_sample;
         job_short_in = 1'b0;
         if (!req_data.last_sample) begin
            seen_in      = n_next;
            job_valid_in = n_next > sma_pkg::COUNT_BITS'(sma_pkg::LAG);
            job_t_in     = n_next - sma_pkg::COUNT_BITS'(sma_pkg::LAG + 1);
         end else begin
            seen_in      = '0;
            job_valid_in = 1'b1;
            if (n_next < sma_pkg::COUNT_BITS'(sma_pkg::HALF_WIN)) begin
               job_short_in = 1'b1;
               job_t_in     = '0;
            end else if (n_next > sma_pkg::COUNT_BITS'(sma_pkg::LAG)) begin
               job_t_in = n_next - sma_pkg::COUNT_BITS'(sma_pkg::LAG + 1);
            end else begin
               job_t_in = '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff      <= '0;
         job_valid_ff <= 1'b0;
      end else begin
         seen_ff      <= seen_in;
         job_valid_ff <= job_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      job_t_ff     <= job_t_in;
      job_n_ff     <= job_n_in;
      job_end_ff   <= job_end_in;
      job_short_ff <= job_short_in;
   end

   // per-tap weight: how many mirrored window positions land on each held sample
   always_comb begin
      win_lo = $signed({2'b00, job_t_ff}) - sma_pkg::POS_BITS'(sma_pkg::HALF_WIN);
      win_hi = $signed({2'b00, job_t_ff}) + sma_pkg::POS_BITS'(sma_pkg::LAG);
      for (int a = 0; a < sma_pkg::WINDOW_LENGTH; a++) begin
         pos[a]          = $signed({2'b00, job_n_ff}) - sma_pkg::POS_BITS'(a + 1);
         mirror_left[a]  = -pos[a] - sma_pkg::POS_BITS'(1);
         mirror_right[a] = $signed({1'b0, job_n_ff, 1'b0}) - sma_pkg::POS_BITS'(1) - pos[a];
         in_record[a]    = (sma_pkg::COUNT_BITS'(a) < job_n_ff) && !job_short_ff;
         self_hit[a]     = in_record[a] && (pos[a] >= win_lo) && (pos[a] <= win_hi);
         left_hit[a]     = in_record[a] && (mirror_left[a] >= win_lo);
         right_hit[a]    = in_record[a] && job_end_ff && (mirror_right[a] <= win_hi);
         weight[a]       = 2'(self_hit[a]) + 2'(left_hit[a]) + 2'(right_hit[a]);
         wide[a]         = sma_pkg::TERM_BITS'(history_ff[a]);
         unique case (weight[a])
            2'd0: term_in[a] = '0;
            2'd1: term_in[a] = wide[a];
            2'd2: term_in[a] = wide[a] <<< 1;
            2'd3: term_in[a] = wide[a] + (wide[a] <<< 1);
         endcase
      end
   end

   // weighted tap stage
   always_ff @(posedge clock) begin
      if (reset) begin
         term_valid_ff <= 1'b0;
      end else if (term_ready) begin
         term_valid_ff <= job_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (term_ready && job_valid_ff) begin
         term_ff       <= term_in;
         term_last_ff  <= job_last;
         term_short_ff <= job_short_ff;
      end
   end

   // first level of the adder tree
   always_comb begin
      for (int g = 0; g < sma_pkg::GROUP_COUNT; g++) begin
         part_in[g] = '0;
         for (int k = 0; k < sma_pkg::GROUP_SIZE; k++) begin
            if (g * sma_pkg::GROUP_SIZE + k < sma_pkg::WINDOW_LENGTH) begin
               part_in[g] = part_in[g] +
                            sma_pkg::SUM_BITS'(term_ff[g * sma_pkg::GROUP_SIZE + k]);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         part_valid_ff <= 1'b0;
      end else if (part_ready) begin
         part_valid_ff <= term_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (part_ready && term_valid_ff) begin
         part_ff       <= part_in;
         part_last_ff  <= term_last_ff;
         part_short_ff <= term_short_ff;
      end
   end

   // final sum into the queue
   always_comb begin
      total = '0;
      for (int g = 0; g < sma_pkg::GROUP_COUNT; g++) begin
         total = total + part_ff[g];
      end
      push_valid              = part_valid_ff;
      push_entry.sum          = total;
      push_entry.last_result  = part_last_ff;
      push_entry.short_record = part_short_ff;
   end

endmodule

// File: hw/rtl/sma_queue.sv
// small register queue decoupling the window front end from the divide back end
module sma_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  sma_pkg::entry_type    in_entry,
   output logic                  out_valid,
   input  logic                  out_ready,
   output sma_pkg::entry_type    out_entry
);

   sma_pkg::entry_type              slot_ff [sma_pkg::QUEUE_DEPTH];
   logic [sma_pkg::QPTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [sma_pkg::QPTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [sma_pkg::QPTR_BITS:0]     count_ff, count_in;
   logic                            push, pop;

   // occupancy and pointers
   always_comb begin
      in_ready  = count_ff != (sma_pkg::QPTR_BITS + 1)'(sma_pkg::QUEUE_DEPTH);
      out_valid = count_ff != '0;
      out_entry = slot_ff[rd_ptr_ff];
      push      = in_valid && in_ready;
      pop       = out_valid && out_ready;
      wr_ptr_in = push ? wr_ptr_ff + sma_pkg::QPTR_BITS'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + sma_pkg::QPTR_BITS'(1) : rd_ptr_ff;
      count_in  = count_ff + (sma_pkg::QPTR_BITS + 1)'(push)
                           - (sma_pkg::QPTR_BITS + 1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= in_entry;
      end
   end

endmodule

// File: hw/rtl/sma_back.sv
// back end: rounded divide of the window sum by the window length, result register
module sma_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  sma_pkg::entry_type    in_entry,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output sma_pkg::rsp_type      rsp_data
);

   logic                                 s1_valid_ff;
   logic [sma_pkg::NUM_BITS-1:0]         s1_num_ff, s1_num_in;
   logic                                 s1_neg_ff, s1_last_ff, s1_short_ff;

   logic                                 s2_valid_ff;
   logic [sma_pkg::NUM_BITS-1:0]         s2_num_ff;
   logic [sma_pkg::EST_BITS-1:0]         s2_est_ff, s2_est_in;
   logic                                 s2_neg_ff, s2_last_ff, s2_short_ff;

   logic                                 out_valid_ff;
   sma_pkg::rsp_type                     out_data_ff, out_data_in;

   logic                                 s1_ready, s2_ready, out_ready;
   logic [sma_pkg::SUM_BITS-1:0]         mag;
   logic [sma_pkg::PROD_BITS-1:0]        prod;
   logic [sma_pkg::NUM_BITS-1:0]         back_mul, rem;
   logic [sma_pkg::EST_BITS-1:0]         quot;
   logic [sma_pkg::SAMPLE_BITS-1:0]      mean_mag;

   // stage handshakes
   always_comb begin
      out_ready = !out_valid_ff || rsp_ready;
      s2_ready  = !s2_valid_ff || out_ready;
      s1_ready  = !s1_valid_ff || s2_ready;
      in_ready  = s1_ready;
      rsp_valid = out_valid_ff;
      rsp_data  = out_data_ff;
   end

   // magnitude and rounding offset
   always_comb begin
      mag       = in_entry.sum[sma_pkg::SUM_BITS-1] ? -in_entry.sum : in_entry.sum;
      s1_num_in = {mag, 1'b0} + sma_pkg::NUM_BITS'(sma_pkg::WINDOW_LENGTH);
   end

   // reciprocal multiply, quotient low by at most one
   always_comb begin
      prod      = sma_pkg::PROD_BITS'(s1_num_ff) * sma_pkg::PROD_BITS'(sma_pkg::RECIP);
      s2_est_in = prod[sma_pkg::RECIP_SHIFT +: sma_pkg::EST_BITS];
   end

   // quotient correction and sign
   always_comb begin
      back_mul = sma_pkg::NUM_BITS'(s2_est_ff) * sma_pkg::NUM_BITS'(sma_pkg::DIVISOR);
      rem      = s2_num_ff - back_mul;
      quot     = s2_est_ff +
                 sma_pkg::EST_BITS'(rem >= sma_pkg::NUM_BITS'(sma_pkg::DIVISOR));
      mean_mag = quot[sma_pkg::SAMPLE_BITS-1:0];
      out_data_in.window_mean  = s2_neg_ff ? -$signed(mean_mag) : $signed(mean_mag);
      out_data_in.last_result  = s2_last_ff;
      out_data_in.short_record = s2_short_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (s1_ready) begin
            s1_valid_ff <= in_valid;
         end
         if (s2_ready) begin
            s2_valid_ff <= s1_valid_ff;
         end
         if (out_ready) begin
            out_valid_ff <= s2_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s1_ready && in_valid) begin
         s1_num_ff   <= s1_num_in;
         s1_neg_ff   <= in_entry.sum[sma_pkg::SUM_BITS-1];
         s1_last_ff  <= in_entry.last_result;
         s1_short_ff <= in_entry.short_record;
      end
      if (s2_ready && s1_valid_ff) begin
         s2_num_ff   <= s1_num_ff;
         s2_est_ff   <= s2_est_in;
         s2_neg_ff   <= s1_neg_ff;
         s2_last_ff  <= s1_last_ff;
         s2_short_ff <= s1_short_ff;
      end
      if (out_ready && s2_valid_ff) begin
         out_data_ff <= out_data_in;
      end
   end

endmodule

// File: hw/rtl/symmetric_moving_average_core.sv
// 17-sample moving average with mirrored record ends: a sample passes the job register,
// tap and partial sum stages, queue, divide stages and result register to result valid, at
// one sample per cycle on an unstalled stream; a final sample holds the input while the
// adder tree takes up to 9 flushed results from the history, one per cycle unless stalled.
// Synchronous active-high reset clears all valid flags, the record count and the
// queue pointers; the sample history is not cleared and is never read across records.
module symmetric_moving_average_core (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  sma_pkg::req_type      req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output sma_pkg::rsp_type      rsp_data
);

   logic                push_valid, push_ready;
   sma_pkg::entry_type  push_entry;
   logic                pop_valid, pop_ready;
   sma_pkg::entry_type  pop_entry;

   // window weighting and summation
   sma_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry)
   );

   // decoupling queue
   sma_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (push_valid),
      .in_ready  (push_ready),
      .in_entry  (push_entry),
      .out_valid (pop_valid),
      .out_ready (pop_ready),
      .out_entry (pop_entry)
   );

   // rounded divide and result register
   sma_back u_back (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (pop_valid),
      .in_ready  (pop_ready),
      .in_entry  (pop_entry),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // short record sums are forced to zero and always close the record
   assert property (@(posedge clock) disable iff (reset)
      push_valid && push_entry.short_record |->
         push_entry.last_result && (push_entry.sum == '0))
      else $error("short record entry without last flag or with nonzero sum");

   // the zero sum of a short record must come out as a zero mean
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.short_record |->
         rsp_data.last_result && (rsp_data.window_mean == '0))
      else $error("short record result with nonzero mean or without last flag");

   // nothing leaves the block in the cycle after reset
   assert property (@(posedge clock) reset |=> !rsp_valid && !pop_valid)
      else $error("result or queue entry valid right after reset");

endmodule

// File: tb/tb_top.sv
// self-checking testbench for the symmetric moving average core
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CLK_PERIOD   = 10;
   localparam int RESET_CYCLES = 3;
   localparam int RANDOM_ITEMS = 415;
   localparam int MAX_GAP      = 4;
   localparam int IDLE_LIMIT   = 200;
   localparam int HOLD_OFF     = 12;
   localparam int DRAIN_CYCLES = 20;

   typedef logic signed [sma_pkg::SAMPLE_BITS-1:0] sample_type;

   // value mixes for the random records
   typedef enum int {MIX_FULL, MIX_RAILS, MIX_SMALL, MIX_NEAR_RAIL} sample_mix_type;

   // typed-in outcome of one directed transaction
   typedef struct {
      bit         fixed;
      int         n_rsp;
      sample_type mean;
      bit         short_flag;
   } fixed_outcome_type;

   typedef struct {
      sma_pkg::req_type  item;
      fixed_outcome_type outcome;
   } directed_row_type;

   localparam fixed_outcome_type FROM_PREDICTOR = '{1'b0, 0, 16'sd0, 1'b0};

   logic             clock     = 1'b0;
   logic             reset     = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   sma_pkg::req_type req_data  = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   sma_pkg::rsp_type rsp_data;

   // predictor state: sample history, newest first, and samples held in this record
   sample_type history [sma_pkg::WINDOW_LENGTH];
   int         record_fill = 0;

   sma_pkg::rsp_type  pending_means[$];
   sma_pkg::rsp_type  step_means[$];
   fixed_outcome_type outcome_notes[$];
   directed_row_type  directed_rows[$];

   int errors        = 0;
   int checked       = 0;
   int sent          = 0;
   int records       = 0;
   int short_records = 0;
   int long_records  = 0;
   int run_length    = 0;
   int idle_cycles   = 0;
   bit rsp_steady    = 1'b0;

   symmetric_moving_average_core i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // sample at a record position, mirrored half-sample past the start or, at_end, the end
   function automatic sample_type mirrored_tap(int pos, int n, bit at_end);
      int p;
      int age;
      p = pos;
      if (p < 0) p = -p - 1;
      else if (at_end && p >= n) p = 2 * n - 1 - p;
      age = n - 1 - p;
      if (age < 0 || age >= sma_pkg::WINDOW_LENGTH) return '0;
      return history[age];
   endfunction

   // window sum over the taps, divided by the length and rounded to nearest
   function automatic sma_pkg::rsp_type window_average(int t, int n, bit at_end,
                                                       bit is_last);
      int               sum;
      int               mag;
      int               q;
      sma_pkg::rsp_type res;
      sum = 0;
      for (int i = 0; i < sma_pkg::WINDOW_LENGTH; i++)
         sum += mirrored_tap(t - sma_pkg::HALF_WIN + i, n, at_end);
      mag = (sum < 0) ? -sum : sum;
      q   = (2 * mag + sma_pkg::WINDOW_LENGTH) / (2 * sma_pkg::WINDOW_LENGTH);
      res.window_mean  = sample_type'((sum < 0) ? -q : q);
      res.last_result  = is_last;
      res.short_record = 1'b0;
      return res;
   endfunction

   // shift in one sample and collect the averages it releases
   function automatic void shift_in_sample(sma_pkg::req_type item);
      int n;
      int first;
      step_means.delete();
      for (int i = sma_pkg::WINDOW_LENGTH - 1; i > 0; i--) history[i] = history[i - 1];
      history[0] = item.sample;
      n = (record_fill + 1 > sma_pkg::WINDOW_LENGTH) ? sma_pkg::WINDOW_LENGTH
                                                      : record_fill + 1;
      if (!item.last_sample) begin
         record_fill = n;
         if (n - 1 - sma_pkg::LAG >= 0)
            step_means.push_back(window_average(n - 1 - sma_pkg::LAG, n, 1'b0, 1'b0));
      end else begin
         record_fill = 0;
         if (n < sma_pkg::HALF_WIN) begin
            step_means.push_back('{window_mean: '0, last_result: 1'b1, short_record: 1'b1});
         end else begin
            first = (n - 1 - sma_pkg::LAG < 0) ? 0 : n - 1 - sma_pkg::LAG;
            for (int t = first; t < n; t++)
               step_means.push_back(window_average(t, n, 1'b1, t == n - 1));
         end
      end
   endfunction

   // offer one sample transaction after a random gap; returns at the falling edge after it
   task automatic send_sample(sma_pkg::req_type item, fixed_outcome_type note, int max_gap);
      int gap;
      gap = $urandom_range(0, max_gap);
      outcome_notes.push_back(note);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
      sent++;
   endtask

   // one well-formed record of random content
   task automatic send_record(int len, sample_mix_type mix, int max_gap);
      sma_pkg::req_type item;
      for (int k = 0; k < len; k++) begin
         case (mix)
            MIX_RAILS: begin
               case ($urandom_range(0, 2))
                  0:       item.sample = 16'sh7fff;
                  1:       item.sample = 16'sh8000;
                  default: item.sample = sample_type'($urandom);
               endcase
            end
            MIX_SMALL: item.sample = sample_type'($urandom_range(0, 64) - 32);
            MIX_NEAR_RAIL: begin
               if ($urandom_range(0, 1))
                  item.sample = sample_type'(32767 - $urandom_range(0, 40));
               else
                  item.sample = sample_type'(-32768 + $urandom_range(0, 40));
            end
            default: item.sample = sample_type'($urandom);
         endcase
         item.last_sample = (k == len - 1);
         send_sample(item, FROM_PREDICTOR, max_gap);
      end
   endtask

   // result sink: random stalls per transaction, with stretches of none
   initial begin : result_sink
      int stall;
      wait (!reset);
      @(negedge clock);
      forever begin
         if ($urandom_range(0, 31) == 0) rsp_steady = !rsp_steady;
         stall = rsp_steady ? 0 : $urandom_range(0, MAX_GAP);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         @(negedge clock);
      end
   end

   // predict on every sample transaction, check every result transaction
   always @(posedge clock) begin : monitor
      fixed_outcome_type note;
      sma_pkg::rsp_type  want;
      if (!reset) begin
         if (req_valid && req_ready) begin
            note = outcome_notes.pop_front();
            shift_in_sample(req_data);
            if (note.fixed) begin
               step_means.delete();
               for (int k = 0; k < note.n_rsp; k++)
                  step_means.push_back('{note.mean, req_data.last_sample && k == note.n_rsp - 1,
                                         note.short_flag});
            end
            foreach (step_means[k]) pending_means.push_back(step_means[k]);
            run_length++;
            if (req_data.last_sample) begin
               records++;
               if (run_length < sma_pkg::HALF_WIN) short_records++;
               if (run_length > sma_pkg::WINDOW_LENGTH) long_records++;
               run_length = 0;
            end
         end
         if (rsp_valid && rsp_ready) begin
            if (pending_means.size() == 0) begin
               errors++;
               $display("%0t: unexpected result: mean %0d last %0b short %0b", $time,
                        rsp_data.window_mean, rsp_data.last_result, rsp_data.short_record);
            end else begin
               want = pending_means.pop_front();
               checked++;
               if (rsp_data.window_mean !== want.window_mean) begin
                  errors++;
                  $display("%0t: window_mean expected %0d actual %0d", $time,
                           want.window_mean, rsp_data.window_mean);
               end
               if (rsp_data.last_result !== want.last_result) begin
                  errors++;
                  $display("%0t: last_result expected %0b actual %0b", $time,
                           want.last_result, rsp_data.last_result);
               end
               if (rsp_data.short_record !== want.short_record) begin
                  errors++;
                  $display("%0t: short_record expected %0b actual %0b", $time,
                           want.short_record, rsp_data.short_record);
               end
            end
         end
         // watchdog on cycles with no transaction on either side
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, IDLE_LIMIT);
            $display("tb: failure");
            $finish;
         end
      end
   end

   initial begin : stimulus
      int len;
      int band;
      bit paused;
      foreach (history[i]) history[i] = '0;

      // single-sample record: the shortest short record
      directed_rows.push_back('{'{16'sh8000, 1'b1}, '{1'b1, 1, 16'sd0, 1'b1}});
      // seven samples: one short of a full half window, still a short record
      directed_rows.push_back('{'{16'sd1, 1'b0}, FROM_PREDICTOR});
      directed_rows.push_back('{'{-16'sd1, 1'b0}, FROM_PREDICTOR});
      directed_rows.push_back('{'{16'sh7fff, 1'b0}, FROM_PREDICTOR});
      directed_rows.push_back('{'{16'sh8000, 1'b0}, FROM_PREDICTOR});
      directed_rows.push_back('{'{16'sd255, 1'b0}, FROM_PREDICTOR});
      directed_rows.push_back('{'{-16'sd256, 1'b0}, FROM_PREDICTOR});
      directed_rows.push_back('{'{16'sd12345, 1'b1}, '{1'b1, 1, 16'sd0, 1'b1}});
      // shortest full record at the top rail: every average is the rail
      for (int k = 0; k < sma_pkg::HALF_WIN; k++)
         directed_rows.push_back('{'{16'sh7fff, k == sma_pkg::HALF_WIN - 1},
                                   '{1'b1, (k == sma_pkg::HALF_WIN - 1) ? sma_pkg::HALF_WIN : 0,
                                     16'sh7fff, 1'b0}});
      // record at the bottom rail whose last sample flushes the most averages
      for (int k = 0; k <= sma_pkg::LAG; k++)
         directed_rows.push_back('{'{16'sh8000, k == sma_pkg::LAG},
                                   '{1'b1, (k == sma_pkg::LAG) ? sma_pkg::LAG + 1 : 0,
                                     16'sh8000, 1'b0}});

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (directed_rows[r])
         send_sample(directed_rows[r].item, directed_rows[r].outcome, MAX_GAP);

      // random records, half of them at least as long as the window
      paused = 1'b0;
      while (sent < directed_rows.size() + RANDOM_ITEMS) begin
         band = $urandom_range(0, 9);
         if (band < 2)
            len = $urandom_range(1, sma_pkg::HALF_WIN - 1);
         else if (band < 5)
            len = $urandom_range(sma_pkg::HALF_WIN, sma_pkg::WINDOW_LENGTH - 1);
         else if (band < 9)
            len = $urandom_range(sma_pkg::WINDOW_LENGTH, 2 * sma_pkg::WINDOW_LENGTH);
         else
            len = $urandom_range(2 * sma_pkg::WINDOW_LENGTH, 4 * sma_pkg::WINDOW_LENGTH);
         send_record(len, sample_mix_type'($urandom_range(0, 3)),
                     ($urandom_range(0, 3) == 0) ? 0 : MAX_GAP);
         // hold the stream once mid-run until every average has drained
         if (!paused && sent >= directed_rows.size() + RANDOM_ITEMS / 2) begin
            paused = 1'b1;
            req_valid <= 1'b0;
            while (pending_means.size() != 0) @(negedge clock);
            repeat (HOLD_OFF) @(negedge clock);
         end
      end

      req_valid <= 1'b0;
      while (pending_means.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      $display("tb: fed %0d samples in %0d records (%0d short, %0d longer than the window)",
               sent, records, short_records, long_records);
      $display("tb: compared %0d averages, %0d field mismatches", checked, errors);
      if (errors == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

// File: sim.f
hw/rtl/sma_pkg.sv
hw/rtl/sma_front.sv
hw/rtl/sma_queue.sv
hw/rtl/sma_back.sv
hw/rtl/symmetric_moving_average_core.sv
tb/tb_top.sv
